// ===== sv/erla_pkg.sv =====
// Shared types, codes and constants for the edge request LRU admission block.
package erla_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 64;

   localparam logic [31:0] CAPACITY_RESET  = 32'd536870912;
   localparam logic [9:0]  MAX_BUSY_RESET  = 10'd100;
   localparam logic [15:0] THRESHOLD_RESET = 16'd1000;
   localparam logic [6:0]  TIME_PER_UNIT   = 7'd100;

   localparam logic [1:0] CSR_CAPACITY  = 2'd0;
   localparam logic [1:0] CSR_MAX_BUSY  = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [2:0] OUT_HIT   = 3'd0;
   localparam logic [2:0] OUT_LOCAL = 3'd1;
   localparam logic [2:0] OUT_FWD   = 3'd2;
   localparam logic [2:0] OUT_FETCH = 3'd3;
   localparam logic [2:0] OUT_DONE  = 3'd4;

   localparam int CNT_REQ   = 0;
   localparam int CNT_HIT   = 1;
   localparam int CNT_MISS  = 2;
   localparam int CNT_LOCAL = 3;
   localparam int CNT_FWD   = 4;
   localparam int CNT_DONE  = 5;

   typedef struct packed {
      logic load;
      logic decide;
      logic evict;
      logic evict_done;
      logic insert;
   } erla_cmd_type;

   typedef struct packed {
      logic insert_req;
      logic evict_need;
      logic oversize;
   } erla_stat_type;

endpackage

// ===== sv/edge_request_lru_admission_top.sv =====
// Top level of the edge request handler with byte-capacity LRU admission.
//  channel   ports                          handshake
//  request   req_kind .. req_task_complexity start high while busy low
//  result    rsp_outcome .. rsp_compute_*   rsp_valid, one cycle strobe
//  config    csr_index, csr_wdata           csr_write_en, no wait
// A completion, a hit or a miss that stores nothing goes from accept through the
// decide state to the result; an insertion adds the check and insert states,
// oversized content the check state, each eviction a walk (victim search, then
// size RAM read). busy stays high through the result strobe, so the next item is
// accepted in the cycle after it at the earliest; the receiver cannot stall.
// Synchronous active-high reset clears state; no clearing pass is needed.
module edge_request_lru_admission_top #(
   parameter int MAX_ENTRIES = erla_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [15:0] req_content_id,
   input  logic [31:0] req_content_size,
   input  logic [15:0] req_task_complexity,
   output logic        rsp_valid,
   output logic [2:0]  rsp_outcome,
   output logic [31:0] rsp_bytes_used,
   output logic [6:0]  rsp_entry_count,
   output logic [9:0]  rsp_busy_tasks,
   output logic [31:0] rsp_request_total,
   output logic [31:0] rsp_hit_total,
   output logic [31:0] rsp_miss_total,
   output logic [31:0] rsp_local_total,
   output logic [31:0] rsp_forward_total,
   output logic [31:0] rsp_done_total,
   output logic [63:0] rsp_compute_time_total,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import erla_pkg::*;

   erla_cmd_type  cmd;
   erla_stat_type stat;

   erla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   erla_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .csr_write_en           (csr_write_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_kind               (req_kind),
      .req_content_id         (req_content_id),
      .req_content_size       (req_content_size),
      .req_task_complexity    (req_task_complexity),
      .rsp_outcome            (rsp_outcome),
      .rsp_bytes_used         (rsp_bytes_used),
      .rsp_entry_count        (rsp_entry_count),
      .rsp_busy_tasks         (rsp_busy_tasks),
      .rsp_request_total      (rsp_request_total),
      .rsp_hit_total          (rsp_hit_total),
      .rsp_miss_total         (rsp_miss_total),
      .rsp_local_total        (rsp_local_total),
      .rsp_forward_total      (rsp_forward_total),
      .rsp_done_total         (rsp_done_total),
      .rsp_compute_time_total (rsp_compute_time_total)
   );
endmodule

// ===== sv/erla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module erla_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/erla_ctrl.sv =====
// Controller state machine: sequences lookup, eviction walk, insertion and response.
module erla_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   input  erla_pkg::erla_stat_type stat,
   output erla_pkg::erla_cmd_type  cmd
);
   import erla_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DECIDE, S_CHECK, S_EVICT, S_INSERT, S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd            = '0;
      state_in       = state_ff;
      cmd.load       = start && (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = stat.insert_req ? S_CHECK : S_RESP;
         end
         S_CHECK: begin
            if (stat.evict_need) begin
               cmd.evict = 1'b1;
               state_in  = S_EVICT;
            end else if (stat.oversize) begin
               state_in = S_RESP;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_EVICT: begin
            cmd.evict_done = 1'b1;
            state_in       = S_CHECK;
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_evict_then_check: assert property (@(posedge clock) disable iff (reset)
      cmd.evict |=> (state_ff == S_EVICT)) else $error("eviction without size update");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> busy) else $error("item accepted but block not busy");
endmodule

// ===== sv/erla_dp.sv =====
// Datapath: entry table, recency ranks, counters and configuration registers.
module erla_dp #(
   parameter int MAX_ENTRIES = erla_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  erla_pkg::erla_cmd_type  cmd,
   output erla_pkg::erla_stat_type stat,
   input  logic                    csr_write_en,
   input  logic [1:0]              csr_index,
   input  logic [31:0]             csr_wdata,
   input  logic                    req_kind,
   input  logic [15:0]             req_content_id,
   input  logic [31:0]             req_content_size,
   input  logic [15:0]             req_task_complexity,
   output logic [2:0]              rsp_outcome,
   output logic [31:0]             rsp_bytes_used,
   output logic [6:0]              rsp_entry_count,
   output logic [9:0]              rsp_busy_tasks,
   output logic [31:0]             rsp_request_total,
   output logic [31:0]             rsp_hit_total,
   output logic [31:0]             rsp_miss_total,
   output logic [31:0]             rsp_local_total,
   output logic [31:0]             rsp_forward_total,
   output logic [31:0]             rsp_done_total,
   output logic [63:0]             rsp_compute_time_total
);
   import erla_pkg::*;

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic          kind_ff;
   logic [15:0]   id_ff;
   logic [31:0]   size_ff;
   logic [15:0]   cx_ff;

   logic          valid_ff [MAX_ENTRIES];
   logic          valid_in [MAX_ENTRIES];
   logic [15:0]   ids_ff   [MAX_ENTRIES];
   logic [15:0]   ids_in   [MAX_ENTRIES];
   logic [IW-1:0] rank_ff  [MAX_ENTRIES];
   logic [IW-1:0] rank_in  [MAX_ENTRIES];

   logic [CW-1:0] vc_ff, vc_in;
   logic [31:0]   used_ff, used_in;
   logic [9:0]    busy_cnt_ff, busy_cnt_in;
   logic [31:0]   cnt_ff [6];
   logic [31:0]   cnt_in [6];
   logic [63:0]   time_ff, time_in;
   logic [2:0]    outcome_ff, outcome_in;
   logic [31:0]   cap_ff, cap_in;
   logic [9:0]    max_busy_ff, max_busy_in;
   logic [15:0]   thr_ff, thr_in;

   logic          hit_any, free_any, victim_any;
   logic [IW-1:0] hit_idx, free_idx, victim_idx;
   logic [IW-1:0] last_rank;
   logic          admit, over;
   logic [22:0]   task_time;
   logic [31:0]   ram_rdata;

   assign last_rank = IW'(vc_ff - CW'(1));

   // parallel tag match, free-slot and victim search
   always_comb begin
      hit_any    = 1'b0;
      hit_idx    = '0;
      free_any   = 1'b0;
      free_idx   = '0;
      victim_any = 1'b0;
      victim_idx = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (!hit_any && valid_ff[i] && ids_ff[i] == id_ff) begin
            hit_any = 1'b1;
            hit_idx = IW'(i);
         end
         if (!free_any && !valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IW'(i);
         end
         if (!victim_any && valid_ff[i] && rank_ff[i] == last_rank) begin
            victim_any = 1'b1;
            victim_idx = IW'(i);
         end
      end
   end

   assign admit     = (busy_cnt_ff < max_busy_ff);
   assign over      = ({1'b0, used_ff} + {1'b0, size_ff}) > {1'b0, cap_ff};
   assign task_time = 23'(cx_ff) * 23'(TIME_PER_UNIT);

   assign stat.insert_req = !kind_ff && !hit_any &&
                            ((cx_ff == '0) || (admit && (cx_ff > thr_ff)));
   assign stat.evict_need = (vc_ff != '0) && (over || vc_ff == CW'(MAX_ENTRIES));
   assign stat.oversize   = (size_ff > cap_ff);

   always_comb begin
      valid_in    = valid_ff;
      ids_in      = ids_ff;
      rank_in     = rank_ff;
      vc_in       = vc_ff;
      used_in     = used_ff;
      busy_cnt_in = busy_cnt_ff;
      cnt_in      = cnt_ff;
      time_in     = time_ff;
      outcome_in  = outcome_ff;
      cap_in      = cap_ff;
      max_busy_in = max_busy_ff;
      thr_in      = thr_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_CAPACITY:  cap_in      = csr_wdata;
            CSR_MAX_BUSY:  max_busy_in = csr_wdata[9:0];
            CSR_THRESHOLD: thr_in      = csr_wdata[15:0];
            default: ;
         endcase
      end

      if (cmd.decide) begin
         if (kind_ff) begin
            if (busy_cnt_ff != '0) busy_cnt_in = busy_cnt_ff - 10'd1;
            cnt_in[CNT_DONE] = cnt_ff[CNT_DONE] + 32'd1;
            outcome_in       = OUT_DONE;
         end else begin
            cnt_in[CNT_REQ] = cnt_ff[CNT_REQ] + 32'd1;
            if (hit_any) begin
               // promote the hit entry, age those that were more recent
               for (int i = 0; i < MAX_ENTRIES; i++) begin
                  if (valid_ff[i] && rank_ff[i] < rank_ff[hit_idx]) begin
                     rank_in[i] = rank_ff[i] + IW'(1);
                  end
               end
               rank_in[hit_idx] = '0;
               cnt_in[CNT_HIT]  = cnt_ff[CNT_HIT] + 32'd1;
               outcome_in       = OUT_HIT;
            end else begin
               cnt_in[CNT_MISS] = cnt_ff[CNT_MISS] + 32'd1;
               if (cx_ff != '0) begin
                  if (admit) begin
                     busy_cnt_in       = busy_cnt_ff + 10'd1;
                     cnt_in[CNT_LOCAL] = cnt_ff[CNT_LOCAL] + 32'd1;
                     time_in           = time_ff + 64'(task_time);
                     outcome_in        = OUT_LOCAL;
                  end else begin
                     cnt_in[CNT_FWD] = cnt_ff[CNT_FWD] + 32'd1;
                     outcome_in      = OUT_FWD;
                  end
               end else begin
                  outcome_in = OUT_FETCH;
               end
            end
         end
      end

      if (cmd.evict) begin
         valid_in[victim_idx] = 1'b0;
         vc_in                = vc_ff - CW'(1);
      end

      if (cmd.evict_done) begin
         used_in = used_ff - ram_rdata;
      end

      if (cmd.insert) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (valid_ff[i]) rank_in[i] = rank_ff[i] + IW'(1);
         end
         valid_in[free_idx] = 1'b1;
         ids_in[free_idx]   = id_ff;
         rank_in[free_idx]  = '0;
         used_in            = used_ff + size_ff;
         vc_in              = vc_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++) valid_ff[i] <= 1'b0;
         for (int k = 0; k < 6; k++) cnt_ff[k] <= '0;
         vc_ff       <= '0;
         used_ff     <= '0;
         busy_cnt_ff <= '0;
         time_ff     <= '0;
         cap_ff      <= CAPACITY_RESET;
         max_busy_ff <= MAX_BUSY_RESET;
         thr_ff      <= THRESHOLD_RESET;
      end else begin
         valid_ff    <= valid_in;
         cnt_ff      <= cnt_in;
         vc_ff       <= vc_in;
         used_ff     <= used_in;
         busy_cnt_ff <= busy_cnt_in;
         time_ff     <= time_in;
         cap_ff      <= cap_in;
         max_busy_ff <= max_busy_in;
         thr_ff      <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         id_ff   <= req_content_id;
         size_ff <= req_content_size;
         cx_ff   <= req_task_complexity;
      end
      ids_ff     <= ids_in;
      rank_ff    <= rank_in;
      outcome_ff <= outcome_in;
   end

   erla_ram #(
      .WIDTH (32),
      .DEPTH (MAX_ENTRIES)
   ) u_size_ram (
      .clock (clock),
      .we    (cmd.insert),
      .waddr (free_idx),
      .wdata (size_ff),
      .raddr (victim_idx),
      .rdata (ram_rdata)
   );

   assign rsp_outcome            = outcome_ff;
   assign rsp_bytes_used         = used_ff;
   assign rsp_entry_count        = 7'(vc_ff);
   assign rsp_busy_tasks         = busy_cnt_ff;
   assign rsp_request_total      = cnt_ff[CNT_REQ];
   assign rsp_hit_total          = cnt_ff[CNT_HIT];
   assign rsp_miss_total         = cnt_ff[CNT_MISS];
   assign rsp_local_total        = cnt_ff[CNT_LOCAL];
   assign rsp_forward_total      = cnt_ff[CNT_FWD];
   assign rsp_done_total         = cnt_ff[CNT_DONE];
   assign rsp_compute_time_total = time_ff;

   logic [MAX_ENTRIES-1:0] valid_vec;
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) valid_vec[i] = valid_ff[i];
   end

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == vc_ff) else $error("entry count out of step with valid bits");
   a_evict_found: assert property (@(posedge clock) disable iff (reset)
      cmd.evict |-> victim_any) else $error("eviction found no least-recent entry");
   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> free_any) else $error("insertion with full entry table");
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the edge request handler with LRU admission.
`timescale 1ns / 1ps

module tb;
   import erla_pkg::*;

   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic [2:0]  outcome;
      logic [31:0] bytes_used;
      logic [6:0]  entry_count;
      logic [9:0]  busy_tasks;
      logic [31:0] totals [6];
      logic [63:0] compute_time;
   } edge_result_type;

   class edge_cache_scoreboard;
      localparam int SLOTS = DEFAULT_MAX_ENTRIES;

      logic [15:0] slot_id   [SLOTS];
      logic [31:0] slot_size [SLOTS];
      bit          slot_live [SLOTS];
      int          slot_rank [SLOTS];
      logic [31:0] used_bytes;
      int          live_count;
      logic [9:0]  busy_count;
      logic [31:0] totals [6];
      logic [63:0] compute_time;
      logic [31:0] capacity;
      logic [9:0]  max_busy;
      logic [15:0] threshold;
      edge_result_type pending [$];
      int          fail_count;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            slot_live[i] = 0;
            slot_rank[i] = 0;
         end
         for (int i = 0; i < 6; i++) totals[i] = '0;
         used_bytes   = '0;
         live_count   = 0;
         busy_count   = '0;
         compute_time = '0;
         capacity     = CAPACITY_RESET;
         max_busy     = MAX_BUSY_RESET;
         threshold    = THRESHOLD_RESET;
         fail_count   = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         if (idx == CSR_CAPACITY) capacity = val;
         else if (idx == CSR_MAX_BUSY) max_busy = val[9:0];
         else if (idx == CSR_THRESHOLD) threshold = val[15:0];
      endfunction

      function void evict_oldest();
         if (live_count == 0) return;
         for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && slot_rank[i] == live_count - 1) begin
               slot_live[i] = 0;
               used_bytes -= slot_size[i];
               live_count--;
               return;
            end
      endfunction

      function void store_content(logic [15:0] id, logic [31:0] size);
         int free_slot;
         free_slot = -1;
         while ({1'b0, used_bytes} + {1'b0, size} > {1'b0, capacity} && live_count > 0)
            evict_oldest();
         if (size > capacity) return;
         if (live_count >= SLOTS) evict_oldest();
         for (int i = 0; i < SLOTS; i++) begin
            if (!slot_live[i]) begin
               if (free_slot < 0) free_slot = i;
            end else begin
               slot_rank[i]++;
            end
         end
         if (free_slot < 0) return;
         slot_live[free_slot] = 1;
         slot_id[free_slot]   = id;
         slot_size[free_slot] = size;
         slot_rank[free_slot] = 0;
         used_bytes += size;
         live_count++;
      endfunction

      function void note_item(logic kind, logic [15:0] id, logic [31:0] size,
                              logic [15:0] cx);
         edge_result_type r;
         int hit_slot;
         hit_slot = -1;
         if (kind) begin
            if (busy_count > 0) busy_count--;
            totals[CNT_DONE]++;
            r.outcome = OUT_DONE;
         end else begin
            totals[CNT_REQ]++;
            for (int i = 0; i < SLOTS; i++)
               if (hit_slot < 0 && slot_live[i] && slot_id[i] == id) hit_slot = i;
            if (hit_slot >= 0) begin
               for (int i = 0; i < SLOTS; i++)
                  if (slot_live[i] && slot_rank[i] < slot_rank[hit_slot]) slot_rank[i]++;
               slot_rank[hit_slot] = 0;
               totals[CNT_HIT]++;
               r.outcome = OUT_HIT;
            end else begin
               totals[CNT_MISS]++;
               if (cx == 0) begin
                  store_content(id, size);
                  r.outcome = OUT_FETCH;
               end else if (busy_count < max_busy) begin
                  busy_count++;
                  totals[CNT_LOCAL]++;
                  compute_time += 64'(cx) * 64'(TIME_PER_UNIT);
                  if (cx > threshold) store_content(id, size);
                  r.outcome = OUT_LOCAL;
               end else begin
                  totals[CNT_FWD]++;
                  r.outcome = OUT_FWD;
               end
            end
         end
         r.bytes_used   = used_bytes;
         r.entry_count  = 7'(live_count);
         r.busy_tasks   = busy_count;
         r.totals       = totals;
         r.compute_time = compute_time;
         pending = {pending, r};
      endfunction

      function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
         end
      endfunction

      function void check_result(edge_result_type got);
         edge_result_type e;
         if (pending.size() == 0) begin
            $error("result with no item outstanding");
            fail_count++;
            return;
         end
         e = pending.pop_front();
         compare("outcome", e.outcome, got.outcome);
         compare("bytes_used", e.bytes_used, got.bytes_used);
         compare("entry_count", e.entry_count, got.entry_count);
         compare("busy_tasks", e.busy_tasks, got.busy_tasks);
         compare("request_total", e.totals[CNT_REQ], got.totals[CNT_REQ]);
         compare("hit_total", e.totals[CNT_HIT], got.totals[CNT_HIT]);
         compare("miss_total", e.totals[CNT_MISS], got.totals[CNT_MISS]);
         compare("local_total", e.totals[CNT_LOCAL], got.totals[CNT_LOCAL]);
         compare("forward_total", e.totals[CNT_FWD], got.totals[CNT_FWD]);
         compare("done_total", e.totals[CNT_DONE], got.totals[CNT_DONE]);
         compare("compute_time_total", e.compute_time, got.compute_time);
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_kind = 0;
   logic [15:0] req_content_id = '0;
   logic [31:0] req_content_size = '0;
   logic [15:0] req_task_complexity = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_outcome;
   logic [31:0] rsp_bytes_used;
   logic [6:0]  rsp_entry_count;
   logic [9:0]  rsp_busy_tasks;
   logic [31:0] rsp_request_total, rsp_hit_total, rsp_miss_total;
   logic [31:0] rsp_local_total, rsp_forward_total, rsp_done_total;
   logic [63:0] rsp_compute_time_total;
   logic        csr_write_en = 0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   edge_cache_scoreboard sb = new();
   bit idle_on;
   int stall_cycles;

   edge_request_lru_admission_top u_dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      edge_result_type got;
      if (!reset && rsp_valid) begin
         got.outcome      = rsp_outcome;
         got.bytes_used   = rsp_bytes_used;
         got.entry_count  = rsp_entry_count;
         got.busy_tasks   = rsp_busy_tasks;
         got.totals[CNT_REQ]   = rsp_request_total;
         got.totals[CNT_HIT]   = rsp_hit_total;
         got.totals[CNT_MISS]  = rsp_miss_total;
         got.totals[CNT_LOCAL] = rsp_local_total;
         got.totals[CNT_FWD]   = rsp_forward_total;
         got.totals[CNT_DONE]  = rsp_done_total;
         got.compute_time = rsp_compute_time_total;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles == STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_item(logic kind, logic [15:0] id, logic [31:0] size,
                            logic [15:0] cx);
      if (idle_on && $urandom_range(99) < 20) begin
         start <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start               <= 1;
      req_kind            <= kind;
      req_content_id      <= id;
      req_content_size    <= size;
      req_task_complexity <= cx;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_item(kind, id, size, cx);
   endtask

   // hold off until every result is back and the block has gone quiet
   task automatic drain();
      start <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_config(logic [31:0] cap, logic [9:0] max_b, logic [15:0] thr);
      drain();
      csr_write_en <= 1; csr_index <= CSR_CAPACITY; csr_wdata <= cap;
      sb.write_reg(CSR_CAPACITY, cap);
      @(posedge clock);
      csr_index <= CSR_MAX_BUSY; csr_wdata <= {22'd0, max_b};
      sb.write_reg(CSR_MAX_BUSY, {22'd0, max_b});
      @(posedge clock);
      csr_index <= CSR_THRESHOLD; csr_wdata <= {16'd0, thr};
      sb.write_reg(CSR_THRESHOLD, {16'd0, thr});
      @(posedge clock);
      csr_write_en <= 0;
      @(posedge clock);
   endtask

   task automatic random_phase(int count, int id_pool, logic [31:0] size_max);
      logic        kind;
      logic [15:0] id, cx;
      logic [31:0] size;
      int          pick;
      for (int n = 0; n < count; n++) begin
         kind = ($urandom_range(99) < 20);
         pick = $urandom_range(99);
         id = (pick < 90) ? 16'($urandom_range(0, id_pool - 1)) : 16'($urandom);
         pick = $urandom_range(99);
         if (pick < 75) size = $urandom_range(0, size_max);
         else if (pick < 85) size = $urandom;
         else if (pick < 92) size = '0;
         else size = 32'hFFFF_FFFF;
         pick = $urandom_range(99);
         if (pick < 40) cx = '0;
         else if (pick < 85) cx = 16'($urandom_range(1, 2000));
         else cx = 16'($urandom);
         send_item(kind, id, size, cx);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset settings first
      idle_on = 1;
      send_item(1, 16'd0, 32'd0, 16'd0);             // completion with nothing busy
      send_item(0, 16'd0, 32'd0, 16'd0);             // miss, fetch, size zero
      send_item(0, 16'd0, 32'd0, 16'd0);             // hit
      send_item(0, 16'hFFFF, 32'd1000, 16'd0);
      send_item(0, 16'h1234, 32'd500, 16'd1000);     // local, at threshold: not stored
      send_item(0, 16'h1234, 32'd500, 16'd1001);     // local, stored
      send_item(0, 16'h1234, 32'd500, 16'd7);        // hit
      send_item(0, 16'h0001, 32'hFFFF_FFFF, 16'd0);  // oversized: empties the cache
      send_item(0, 16'h0002, 32'd9, 16'hFFFF);
      send_item(1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      set_config(32'd100, 10'd1, 16'd0);
      send_item(0, 16'h0010, 32'd60, 16'd0);
      send_item(0, 16'h0011, 32'd40, 16'd0);
      send_item(0, 16'h0010, 32'd60, 16'd0);         // hit, reorder
      send_item(0, 16'h0012, 32'd30, 16'd0);         // evicts the least recent
      send_item(0, 16'h0013, 32'd1, 16'd5);          // forwarded
      send_item(0, 16'h0014, 32'd1, 16'd5);          // forwarded
      send_item(1, 16'd0, 32'd0, 16'd0);
      set_config(32'd50, 10'd0, 16'hFFFF);           // capacity now below usage
      send_item(0, 16'h0015, 32'd1, 16'hFFFF);       // forwarded
      send_item(0, 16'h0016, 32'd10, 16'd0);         // insert evicts down to fit
      send_item(0, 16'h0017, 32'd51, 16'd0);         // oversized
      set_config(32'd0, 10'd0, 16'd0);
      send_item(0, 16'h0018, 32'd0, 16'd0);

      // random phases across settings
      set_config(32'hFFFF_FFFF, 10'd1023, 16'd0);
      random_phase(350, 90, 32'd100000);
      idle_on = 0;
      set_config(32'd5000, 10'd3, 16'd500);
      random_phase(350, 40, 32'd900);
      idle_on = 1;
      set_config(32'd0, 10'd0, 16'hFFFF);
      random_phase(200, 20, 32'd10);
      set_config(CAPACITY_RESET, MAX_BUSY_RESET, THRESHOLD_RESET);
      random_phase(450, 100, 32'd4000000);
      set_config(32'd20000, 10'd1023, 16'd100);
      random_phase(400, 120, 32'd400);

      drain();
      repeat (20) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ===== files.f =====
sv/erla_pkg.sv
sv/erla_ram.sv
sv/erla_ctrl.sv
sv/erla_dp.sv
sv/edge_request_lru_admission_top.sv
tb/tb.sv
